// ----- sv/assert_macros.svh -----
// Assertion macros used by the RTL of the bank-switch mapper.
// Depends on nothing; the body is empty in synthesis builds.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SBSM_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("sbsm assertion failed");
`define SBSM_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("sbsm assertion failed");
`else
`define SBSM_ASSERT(lbl, clk, rst_n, prop)
`define SBSM_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// ----- sv/sbsm_pkg.sv -----
// Types and constants of the serial bank-switch mapper.
// Used by the top level serial_bank_switch_mapper_unit.
`timescale 1ns / 1ps
`default_nettype none
package sbsm_pkg;

    typedef enum logic [2:0] {
        CMD_CPU_WRITE = 3'd0,
        CMD_PRG_READ  = 3'd1,
        CMD_CHR_READ  = 3'd2,
        CMD_CHR_WRITE = 3'd3,
        CMD_PRG_RAM   = 3'd4
    } cmd_t;

    typedef enum logic [2:0] {
        REG_VARIANT      = 3'd0,
        REG_PRG_ROM_SIZE = 3'd1,
        REG_CHR_ROM_SIZE = 3'd2,
        REG_CHR_RAM_SIZE = 3'd3,
        REG_PRG_RAM_SIZE = 3'd4
    } reg_idx_t;

    localparam logic [1:0] VAR_STANDARD = 2'd0;
    localparam logic [1:0] VAR_FIXED32K = 2'd1;
    localparam logic [1:0] VAR_MMC1A    = 2'd2;
    localparam logic [1:0] VAR_DOUBLED  = 2'd3;

    localparam logic [4:0]  SHIFT_MARK   = 5'h10;
    localparam logic [4:0]  CTRL_RESET   = 5'h0C;
    localparam logic [19:0] OUTER_SIZE   = 20'h40000;
    localparam logic [18:0] HALF_SIZE    = 19'h20000;
    localparam logic [3:0]  SH_32K       = 4'd15;
    localparam logic [3:0]  SH_16K       = 4'd14;
    localparam logic [3:0]  SH_8K        = 4'd13;
    localparam logic [3:0]  SH_4K        = 4'd12;
    localparam int          DIV_STEPS    = 32;

    typedef struct packed {
        logic [2:0]  command;
        logic [15:0] address;
        logic [7:0]  write_data;
        logic [63:0] cpu_cycle;
    } in_item_t;

    typedef struct packed {
        logic        accepted;
        logic [18:0] mapped_address;
        logic [1:0]  mirroring;
    } out_item_t;

endpackage
`default_nettype wire

// ----- sv/serial_bank_switch_mapper_unit.sv -----
// Serial bank-switch mapper: serial register load and address translation.
// Sequence from accept to result: CPU write: setup, done; PRG RAM map: setup, 32 bank
// remainder steps, combine, done; PRG ROM or CHR map adds 32 steps for the size.
// Throughput: one item at a time, set by the shared one-bit-a-step remainder unit.
// The output register lets the next item start while a result waits.
// Reset (aresetn low, synchronous) restores config and mapper state; not the datapath.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module serial_bank_switch_mapper_unit (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire sbsm_pkg::in_item_t s_item,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output sbsm_pkg::out_item_t     m_item,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [19:0]        cfg_data
);
    import sbsm_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_SETUP = 6'b000010,
        ST_MOD1  = 6'b000100,
        ST_COMB  = 6'b001000,
        ST_MOD2  = 6'b010000,
        ST_DONE  = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [1:0]  variant_reg;
    logic [19:0] prg_rom_size_reg;
    logic [17:0] chr_rom_size_reg, chr_ram_size_reg;
    logic [15:0] prg_ram_size_reg;

    // mapper state
    logic [4:0]  load_shift_reg, load_shift_next;
    logic [4:0]  control_reg, control_next;
    logic [4:0]  chr_low_reg, chr_low_next;
    logic [4:0]  chr_high_reg, chr_high_next;
    logic [4:0]  prg_bank_reg, prg_bank_next;
    logic [63:0] last_cyc_reg, last_cyc_next;

    // item and datapath
    in_item_t    item_reg;
    logic        ok_reg, ok_next;
    logic        fin_reg, fin_next;
    logic [31:0] pre_reg, pre_next;
    logic [15:0] off_reg, off_next;
    logic [3:0]  shamt_reg, shamt_next;
    logic [19:0] fdiv_reg, fdiv_next;
    logic [31:0] m_reg, m_next;

    // shared remainder unit
    logic [31:0] dq_reg, dq_next;
    logic [19:0] dv_reg, dv_next;
    logic [19:0] rem_reg, rem_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [20:0] trial;

    logic        m_valid_reg, m_valid_next;
    out_item_t   m_item_reg, m_item_next;

    // setup decode
    logic [4:0]  bank_s;
    logic [19:0] total_s, count_s;
    logic [19:0] base_s, rbase_s;
    logic [18:0] rsize_s, hsize_s, hrest_s;
    logic [18:0] hbase_s;
    logic [1:0]  mode_s;
    logic [4:0]  preg_s;
    logic        half_s;
    logic [17:0] csize_s;
    logic        ignore_s;
    logic        hi_s;

    // assertion helpers
    logic        div_busy;
    logic        rejected_out;

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_item    = m_item_reg;

    assign trial = {rem_reg, dq_reg[31]};

    assign div_busy     = (state_reg == ST_MOD1) || (state_reg == ST_MOD2);
    assign rejected_out = m_valid && !m_item.accepted;

    always_comb begin
        // PRG geometry
        base_s  = (prg_rom_size_reg > OUTER_SIZE && chr_low_reg[4]) ? OUTER_SIZE : 20'd0;
        rbase_s = prg_rom_size_reg - base_s;
        rsize_s = (rbase_s > OUTER_SIZE) ? OUTER_SIZE[18:0] : rbase_s[18:0];
        mode_s  = control_reg[3:2];
        preg_s  = (variant_reg == VAR_DOUBLED) ? {prg_bank_reg[3:0], 1'b0} : prg_bank_reg;
        half_s  = (variant_reg == VAR_MMC1A) && prg_bank_reg[4] && (rsize_s > HALF_SIZE);
        hbase_s = (half_s && prg_bank_reg[3]) ? HALF_SIZE : 19'd0;
        hrest_s = rsize_s - hbase_s;
        hsize_s = half_s ? ((hrest_s > HALF_SIZE) ? HALF_SIZE : hrest_s) : rsize_s;
        hi_s    = item_reg.address[15] && item_reg.address[14];
        csize_s = (chr_rom_size_reg != 18'd0) ? chr_rom_size_reg : chr_ram_size_reg;
        ignore_s = (item_reg.cpu_cycle != '1) && (last_cyc_reg != '1)
                   && (item_reg.cpu_cycle <= last_cyc_reg + 64'd1);

        state_next      = state_reg;
        load_shift_next = load_shift_reg;
        control_next    = control_reg;
        chr_low_next    = chr_low_reg;
        chr_high_next   = chr_high_reg;
        prg_bank_next   = prg_bank_reg;
        last_cyc_next   = last_cyc_reg;
        ok_next    = ok_reg;
        fin_next   = fin_reg;
        pre_next   = pre_reg;
        off_next   = off_reg;
        shamt_next = shamt_reg;
        fdiv_next  = fdiv_reg;
        m_next     = m_reg;
        dq_next    = dq_reg;
        dv_next    = dv_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        bank_s     = 5'd0;
        total_s    = 20'd0;
        count_s    = 20'd1;
        m_valid_next = m_valid_reg && !m_ready;
        m_item_next  = m_item_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP: begin
                ok_next    = 1'b0;
                fin_next   = 1'b1;
                pre_next   = 32'd0;
                off_next   = 16'd0;
                shamt_next = SH_16K;
                fdiv_next  = prg_rom_size_reg;
                state_next = ST_DONE;
                case (item_reg.command)
                    CMD_CPU_WRITE: begin
                        if (item_reg.address[15]) begin
                            ok_next = 1'b1;
                            if (item_reg.write_data[7]) begin
                                if (item_reg.cpu_cycle != '1) begin
                                    last_cyc_next = item_reg.cpu_cycle;
                                end
                                load_shift_next = SHIFT_MARK;
                                control_next    = control_reg | CTRL_RESET;
                            end else if (!ignore_s) begin
                                if (item_reg.cpu_cycle != '1) begin
                                    last_cyc_next = item_reg.cpu_cycle;
                                end
                                load_shift_next = {item_reg.write_data[0], load_shift_reg[4:1]};
                                if (load_shift_reg[0]) begin
                                    // fifth bit: load the target register
                                    load_shift_next = SHIFT_MARK;
                                    unique case (item_reg.address[14:13])
                                        2'd0: control_next  = {item_reg.write_data[0],
                                                               load_shift_reg[4:1]};
                                        2'd1: chr_low_next  = {item_reg.write_data[0],
                                                               load_shift_reg[4:1]};
                                        2'd2: chr_high_next = {item_reg.write_data[0],
                                                               load_shift_reg[4:1]};
                                        default: prg_bank_next = {item_reg.write_data[0],
                                                                  load_shift_reg[4:1]};
                                    endcase
                                end
                            end
                        end
                    end
                    CMD_PRG_READ: begin
                        if (item_reg.address[15] && prg_rom_size_reg != 20'd0) begin
                            ok_next  = 1'b1;
                            off_next = {1'b0, item_reg.address[14:0]};
                            if (variant_reg == VAR_FIXED32K) begin
                                pre_next = 32'd0;
                            end else if (!mode_s[1]) begin
                                pre_next   = 32'(base_s);
                                bank_s     = {2'd0, preg_s[3:1]};
                                total_s    = 20'(rsize_s);
                                shamt_next = SH_32K;
                            end else if (mode_s == 2'd2 && !hi_s) begin
                                pre_next = 32'(base_s) + 32'(hbase_s);
                            end else if (mode_s == 2'd3 && hi_s) begin
                                // fixed last bank; wraps when the ROM is tiny
                                pre_next = 32'(base_s) + 32'(hbase_s) + 32'(hsize_s)
                                           - 32'h4000;
                                off_next = {2'd0, item_reg.address[13:0]};
                            end else begin
                                off_next = {2'd0, item_reg.address[13:0]};
                                if (half_s) begin
                                    pre_next = 32'(base_s) + 32'(hbase_s);
                                    bank_s   = {2'd0, preg_s[2:0]};
                                    total_s  = 20'(hsize_s);
                                end else begin
                                    pre_next = 32'(base_s);
                                    bank_s   = {1'b0, preg_s[3:0]};
                                    total_s  = 20'(rsize_s);
                                end
                            end
                            state_next = ST_MOD1;
                        end
                    end
                    CMD_CHR_READ, CMD_CHR_WRITE: begin
                        if (!item_reg.address[15] && !item_reg.address[14]
                            && !item_reg.address[13] && csize_s != 18'd0
                            && (item_reg.command == CMD_CHR_READ
                                || chr_ram_size_reg != 18'd0)) begin
                            ok_next    = 1'b1;
                            shamt_next = SH_4K;
                            total_s    = 20'(csize_s);
                            fdiv_next  = 20'(csize_s);
                            if (!control_reg[4]) begin
                                bank_s   = {chr_low_reg[4:1], 1'b0};
                                off_next = {3'd0, item_reg.address[12:0]};
                            end else if (!item_reg.address[12]) begin
                                bank_s   = chr_low_reg;
                                off_next = {4'd0, item_reg.address[11:0]};
                            end else begin
                                bank_s   = chr_high_reg;
                                off_next = {4'd0, item_reg.address[11:0]};
                            end
                            state_next = ST_MOD1;
                        end
                    end
                    CMD_PRG_RAM: begin
                        if (item_reg.address[15:13] == 3'b011 && prg_ram_size_reg != 16'd0
                            && (variant_reg == VAR_MMC1A || !prg_bank_reg[4])) begin
                            ok_next    = 1'b1;
                            fin_next   = 1'b0;
                            shamt_next = SH_8K;
                            total_s    = 20'(prg_ram_size_reg);
                            off_next   = {3'd0, item_reg.address[12:0]};
                            if (prg_ram_size_reg[15]) begin
                                bank_s = {3'd0, chr_low_reg[3:2]};
                            end else if (prg_ram_size_reg[14]) begin
                                bank_s = {4'd0, chr_low_reg[3]};
                            end
                            state_next = ST_MOD1;
                        end
                    end
                    default: begin
                        ok_next = 1'b0;
                    end
                endcase
                count_s  = total_s >> shamt_next;
                if (count_s == 20'd0) begin
                    count_s = 20'd1;
                end
                dq_next  = 32'(bank_s);
                dv_next  = count_s;
                rem_next = 20'd0;
                cnt_next = 5'(DIV_STEPS - 1);
            end
            ST_MOD1, ST_MOD2: begin
                if (trial >= {1'b0, dv_reg}) begin
                    rem_next = 20'(trial - {1'b0, dv_reg});
                end else begin
                    rem_next = trial[19:0];
                end
                dq_next  = {dq_reg[30:0], 1'b0};
                cnt_next = cnt_reg - 5'd1;
                if (cnt_reg == 5'd0) begin
                    state_next = (state_reg == ST_MOD1) ? ST_COMB : ST_DONE;
                end
            end
            ST_COMB: begin
                m_next   = pre_reg + (32'(rem_reg) << shamt_reg) + 32'(off_reg);
                dq_next  = pre_reg + (32'(rem_reg) << shamt_reg) + 32'(off_reg);
                dv_next  = fdiv_reg;
                rem_next = 20'd0;
                cnt_next = 5'(DIV_STEPS - 1);
                state_next = fin_reg ? ST_MOD2 : ST_DONE;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_item_next.accepted  = ok_reg;
                    m_item_next.mirroring = control_reg[1:0];
                    if (!ok_reg || item_reg.command == CMD_CPU_WRITE) begin
                        m_item_next.mapped_address = 19'd0;
                    end else if (fin_reg) begin
                        m_item_next.mapped_address = rem_reg[18:0];
                    end else begin
                        m_item_next.mapped_address = m_reg[18:0];
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            m_valid_reg      <= 1'b0;
            variant_reg      <= VAR_STANDARD;
            prg_rom_size_reg <= 20'h40000;
            chr_rom_size_reg <= 18'd0;
            chr_ram_size_reg <= 18'h2000;
            prg_ram_size_reg <= 16'h2000;
            load_shift_reg   <= SHIFT_MARK;
            control_reg      <= CTRL_RESET;
            chr_low_reg      <= 5'd0;
            chr_high_reg     <= 5'd0;
            prg_bank_reg     <= 5'd0;
            last_cyc_reg     <= '1;
        end else begin
            state_reg      <= state_next;
            m_valid_reg    <= m_valid_next;
            load_shift_reg <= load_shift_next;
            control_reg    <= control_next;
            chr_low_reg    <= chr_low_next;
            chr_high_reg   <= chr_high_next;
            prg_bank_reg   <= prg_bank_next;
            last_cyc_reg   <= last_cyc_next;
            if (cfg_valid) begin
                case (cfg_index)
                    REG_VARIANT:      variant_reg      <= cfg_data[1:0];
                    REG_PRG_ROM_SIZE: prg_rom_size_reg <= cfg_data;
                    REG_CHR_ROM_SIZE: chr_rom_size_reg <= cfg_data[17:0];
                    REG_CHR_RAM_SIZE: chr_ram_size_reg <= cfg_data[17:0];
                    REG_PRG_RAM_SIZE: prg_ram_size_reg <= cfg_data[15:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
        ok_reg     <= ok_next;
        fin_reg    <= fin_next;
        pre_reg    <= pre_next;
        off_reg    <= off_next;
        shamt_reg  <= shamt_next;
        fdiv_reg   <= fdiv_next;
        m_reg      <= m_next;
        dq_reg     <= dq_next;
        dv_reg     <= dv_next;
        rem_reg    <= rem_next;
        cnt_reg    <= cnt_next;
        m_item_reg <= m_item_next;
    end

    `SBSM_ASSERT(a_shift_mark, aclk, aresetn, load_shift_reg != 5'd0)
    `SBSM_ASSERT(a_rem_bound, aclk, aresetn, div_busy |-> (rem_reg < dv_reg))
    `SBSM_ASSERT(a_reject_zero, aclk, aresetn, rejected_out |-> (m_item.mapped_address == 19'd0))
    `SBSM_ASSERT(a_busy_not_ready, aclk, aresetn, (s_valid && s_ready) |=> !s_ready)

endmodule
`default_nettype wire

// ----- tb/sv/tb_top.sv -----
// Self-checking bench for serial_bank_switch_mapper_unit: drives accesses and
// register writes, predicts each result in place. Depends on sbsm_pkg and the unit.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
    import sbsm_pkg::*;

    localparam logic [63:0] CYC_UNKNOWN = '1;
    localparam int          CYCLE_LIMIT = 3000000;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_item = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_item;
    logic      cfg_valid = 1'b0;
    logic      cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [19:0] cfg_data = '0;

    always #5 aclk = ~aclk;

    serial_bank_switch_mapper_unit i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_item(s_item),
        .m_valid(m_valid), .m_ready(m_ready), .m_item(m_item),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // mapper shadow state
    logic [1:0]  cur_variant;
    logic [31:0] cur_prg_rom, cur_chr_rom, cur_chr_ram, cur_prg_ram;
    logic [4:0]  shift_reg, ctrl_reg, chr_lo, chr_hi, prg_reg;
    logic [63:0] last_cyc;

    out_item_t expected_q[$];
    int  err_count = 0;
    int  out_count = 0;
    int  cycle_count = 0;
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    logic [63:0] cyc_now = 64'd100;

    function automatic logic [31:0] bank_offset(logic [31:0] bank, logic [31:0] bsize,
                                                logic [31:0] total, logic [31:0] off);
        logic [31:0] count;
        count = total / bsize;
        if (count == 0) count = 1;
        return (bank % count) * bsize + off;
    endfunction

    task automatic write_serial(input logic [15:0] addr, input logic [7:0] data,
                                input logic [63:0] cyc, output logic ok);
        logic done;
        logic [4:0] value;
        ok = 1'b0;
        if (addr < 16'h8000) return;
        ok = 1'b1;
        if (data[7]) begin
            if (cyc != CYC_UNKNOWN) last_cyc = cyc;
            shift_reg = SHIFT_MARK;
            ctrl_reg = ctrl_reg | CTRL_RESET;
            return;
        end
        if (cyc != CYC_UNKNOWN) begin
            if (last_cyc != CYC_UNKNOWN && cyc <= last_cyc + 64'd1) return;
            last_cyc = cyc;
        end
        done = shift_reg[0];
        shift_reg = {data[0], shift_reg[4:1]};
        if (!done) return;
        value = shift_reg;
        shift_reg = SHIFT_MARK;
        case (addr[14:13])
            2'd0: ctrl_reg = value;
            2'd1: chr_lo = value;
            2'd2: chr_hi = value;
            default: prg_reg = value;
        endcase
    endtask

    function automatic logic map_prg(logic [15:0] addr, output logic [31:0] res);
        logic [31:0] base, rsize, hbase, hsize, m, reg_v, off, a;
        logic [1:0] mode;
        logic half;
        res = 0;
        a = {16'd0, addr};
        if (addr < 16'h8000 || cur_prg_rom == 0) return 1'b0;
        if (cur_variant == VAR_FIXED32K) begin
            res = (a - 32'h8000) % cur_prg_rom;
            return 1'b1;
        end
        base = (cur_prg_rom > OUTER_SIZE && chr_lo[4]) ? 32'h40000 : 32'h0;
        rsize = cur_prg_rom - base;
        if (rsize > OUTER_SIZE) rsize = 32'(OUTER_SIZE);
        mode = ctrl_reg[3:2];
        reg_v = (cur_variant == VAR_DOUBLED) ? {27'd0, prg_reg[3:0], 1'b0} : {27'd0, prg_reg};
        half = cur_variant == VAR_MMC1A && prg_reg[4] && rsize > HALF_SIZE;
        hbase = 0;
        hsize = rsize;
        if (half) begin
            hbase = prg_reg[3] ? 32'h20000 : 32'h0;
            hsize = rsize - hbase;
            if (hsize > HALF_SIZE) hsize = 32'(HALF_SIZE);
        end
        if (mode < 2)
            m = base + bank_offset((reg_v & 32'hE) >> 1, 32'h8000, rsize, a - 32'h8000);
        else if (mode == 2 && addr < 16'hC000)
            m = base + hbase + (a - 32'h8000);
        else if (mode == 3 && addr >= 16'hC000)
            m = base + hbase + hsize - 32'h4000 + (a - 32'hC000);
        else begin
            off = a - ((mode == 2) ? 32'hC000 : 32'h8000);
            if (half) m = base + hbase + bank_offset(reg_v & 32'h7, 32'h4000, hsize, off);
            else m = base + bank_offset(reg_v & 32'hF, 32'h4000, rsize, off);
        end
        res = m % cur_prg_rom;
        return 1'b1;
    endfunction

    function automatic logic map_chr(logic [15:0] addr, output logic [31:0] res);
        logic [31:0] size, m;
        res = 0;
        size = (cur_chr_rom != 0) ? cur_chr_rom : cur_chr_ram;
        if (addr >= 16'h2000 || size == 0) return 1'b0;
        if (!ctrl_reg[4])
            m = bank_offset({27'd0, chr_lo & 5'h1E}, 32'h1000, size, {16'd0, addr});
        else if (addr < 16'h1000)
            m = bank_offset({27'd0, chr_lo}, 32'h1000, size, {16'd0, addr});
        else
            m = bank_offset({27'd0, chr_hi}, 32'h1000, size, {16'd0, addr - 16'h1000});
        res = m % size;
        return 1'b1;
    endfunction

    function automatic logic map_ram(logic [15:0] addr, output logic [31:0] res);
        logic [31:0] bank;
        res = 0;
        bank = 0;
        if (addr < 16'h6000 || addr > 16'h7FFF || cur_prg_ram == 0) return 1'b0;
        if (cur_variant != VAR_MMC1A && prg_reg[4]) return 1'b0;
        if (cur_prg_ram >= 32'h8000) bank = {30'd0, chr_lo[3:2]};
        else if (cur_prg_ram >= 32'h4000) bank = {31'd0, chr_lo[3]};
        res = bank_offset(bank, 32'h2000, cur_prg_ram, {16'd0, addr - 16'h6000});
        return 1'b1;
    endfunction

    task automatic predict_access(input in_item_t it, output out_item_t r);
        logic ok;
        logic [31:0] m;
        m = 0;
        case (it.command)
            CMD_CPU_WRITE: write_serial(it.address, it.write_data, it.cpu_cycle, ok);
            CMD_PRG_READ:  ok = map_prg(it.address, m);
            CMD_CHR_READ:  ok = map_chr(it.address, m);
            CMD_CHR_WRITE: ok = (cur_chr_ram != 0) && map_chr(it.address, m);
            CMD_PRG_RAM:   ok = map_ram(it.address, m);
            default:       ok = 1'b0;
        endcase
        if (!ok) m = 0;
        r.accepted = ok;
        r.mapped_address = m[18:0];
        r.mirroring = ctrl_reg[1:0];
    endtask

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("serial_bank_switch_mapper_unit: mismatch");
            $finish;
        end
    end

    // result checker
    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            out_count <= out_count + 1;
            if (expected_q.size() == 0) begin
                err_count++;
                if (err_count <= 10) $display("unexpected result %p", m_item);
            end else begin
                want = expected_q.pop_front();
                if (m_item !== want) begin
                    err_count++;
                    if (err_count <= 10)
                        $display("result mismatch: expected %p got %p", want, m_item);
                end
            end
        end
    end

    // receiver stalls
    always @(negedge aclk)
        m_ready <= ($urandom_range(99) >= recv_stall_pct);

    // valid stays up between writes; the caller drops it after the last one
    task automatic write_reg(input reg_idx_t idx, input logic [19:0] val);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        case (idx)
            REG_VARIANT:      cur_variant = val[1:0];
            REG_PRG_ROM_SIZE: cur_prg_rom = {12'd0, val};
            REG_CHR_ROM_SIZE: cur_chr_rom = {14'd0, val[17:0]};
            REG_CHR_RAM_SIZE: cur_chr_ram = {14'd0, val[17:0]};
            default:          cur_prg_ram = {16'd0, val[15:0]};
        endcase
    endtask

    // check against a typed value only where one is given, else predictor alone
    task automatic send_access(input in_item_t it, input logic has_fixed,
                               input out_item_t fixed_r);
        out_item_t r;
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
            while ($urandom_range(99) < send_idle_pct) @(negedge aclk);
        end
        predict_access(it, r);
        if (has_fixed && r !== fixed_r) begin
            err_count++;
            if (err_count <= 10) $display("table row: expected %p predicted %p", fixed_r, r);
        end
        expected_q.insert(expected_q.size(), r);
        s_item <= it;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic drain(input int tail);
        s_valid <= 1'b0;
        @(negedge aclk);
        while (expected_q.size() != 0) @(negedge aclk);
        repeat (tail) @(negedge aclk);
    endtask

    function automatic in_item_t mk(cmd_t c, logic [15:0] a, logic [7:0] d, logic [63:0] cy);
        in_item_t it;
        it.command = c;
        it.address = a;
        it.write_data = d;
        it.cpu_cycle = cy;
        return it;
    endfunction

    function automatic out_item_t ores(logic ok, logic [18:0] m, logic [1:0] mir);
        out_item_t r;
        r.accepted = ok;
        r.mapped_address = m;
        r.mirroring = mir;
        return r;
    endfunction

    // directed table
    typedef struct {
        in_item_t  it;
        logic      fixed;
        out_item_t res;
    } row_t;
    row_t dir_rows[$];

    task automatic add_row(in_item_t it, logic fixed, out_item_t r);
        row_t row;
        row.it = it;
        row.fixed = fixed;
        row.res = r;
        dir_rows.insert(dir_rows.size(), row);
    endtask

    // one serial register load of five bits with spaced cycles
    task automatic serial_load(input logic [15:0] addr, input logic [4:0] val);
        for (int b = 0; b < 5; b++) begin
            cyc_now += $urandom_range(3, 2);
            send_access(mk(CMD_CPU_WRITE, addr, {1'b0, 6'($urandom_range(63)), val[b]},
                           ($urandom_range(15) == 0) ? CYC_UNKNOWN : cyc_now), 0, '0);
        end
    endtask

    function automatic in_item_t rand_access();
        in_item_t it;
        int k;
        it.command = cmd_t'($urandom_range(4));
        if ($urandom_range(30) == 0) it.command = cmd_t'($urandom_range(7, 5));
        k = $urandom_range(9);
        it.address = 16'($urandom);
        if (it.command == CMD_CHR_READ || it.command == CMD_CHR_WRITE)
            if (k < 8) it.address = 16'($urandom_range(16'h1FFF));
        if (it.command == CMD_PRG_RAM && k < 8)
            it.address = 16'($urandom_range(16'h7FFF, 16'h6000));
        if (it.command == CMD_PRG_READ && k < 8)
            it.address = 16'($urandom_range(16'hFFFF, 16'h8000));
        it.write_data = 8'($urandom);
        it.cpu_cycle = {$urandom, $urandom};
        if (k == 0) it.cpu_cycle = CYC_UNKNOWN;
        else if (k < 7) begin
            cyc_now += $urandom_range(2, 1);
            it.cpu_cycle = cyc_now;
        end
        return it;
    endfunction

    initial begin
        int phase;
        logic [19:0] prg_sizes[6];
        logic [19:0] chr_sizes[5];
        logic [19:0] ram_sizes[5];
        prg_sizes = '{20'h80000, 20'h40000, 20'h8000, 20'h2000, 20'h0, 20'hFFFFF};
        chr_sizes = '{20'h0, 20'h20000, 20'h2000, 20'h3FFFF, 20'h1000};
        ram_sizes = '{20'h2000, 20'h8000, 20'h4000, 20'h0, 20'h800};
        cur_variant = VAR_STANDARD;
        cur_prg_rom = 32'h40000;
        cur_chr_rom = 0;
        cur_chr_ram = 32'h2000;
        cur_prg_ram = 32'h2000;
        shift_reg = SHIFT_MARK;
        ctrl_reg = CTRL_RESET;
        chr_lo = 0;
        chr_hi = 0;
        prg_reg = 0;
        last_cyc = CYC_UNKNOWN;

        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // after reset: 16K mode with last bank fixed at 0xC000
        add_row(mk(CMD_PRG_READ, 16'h8000, 0, 0), 1, ores(1, 19'h0, 0));
        add_row(mk(CMD_PRG_READ, 16'hFFFF, 0, 0), 1, ores(1, 19'h3FFFF, 0));
        add_row(mk(CMD_PRG_READ, 16'h7FFF, 0, 0), 1, ores(0, 19'h0, 0));
        add_row(mk(CMD_CHR_READ, 16'h0000, 0, 0), 1, ores(1, 19'h0, 0));
        add_row(mk(CMD_CHR_READ, 16'h1FFF, 0, 0), 1, ores(1, 19'h1FFF, 0));
        add_row(mk(CMD_CHR_WRITE, 16'h2000, 0, 0), 1, ores(0, 19'h0, 0));
        add_row(mk(CMD_PRG_RAM, 16'h6000, 0, 0), 1, ores(1, 19'h0, 0));
        add_row(mk(CMD_PRG_RAM, 16'h7FFF, 0, 0), 1, ores(1, 19'h1FFF, 0));
        add_row(mk(CMD_PRG_RAM, 16'h8000, 0, 0), 1, ores(0, 19'h0, 0));
        add_row(mk(cmd_t'(3'd7), 16'hFFFF, 8'hFF, '1), 1, ores(0, 19'h0, 0));
        add_row(mk(CMD_CPU_WRITE, 16'h7FFF, 8'h01, 10), 1, ores(0, 19'h0, 0));
        // load 0x0F into the PRG bank via five writes, one repeat ignored
        add_row(mk(CMD_CPU_WRITE, 16'h8000, 8'h01, 20), 1, ores(1, 0, 0));
        add_row(mk(CMD_CPU_WRITE, 16'h8000, 8'h00, 21), 1, ores(1, 0, 0));
        add_row(mk(CMD_CPU_WRITE, 16'h8000, 8'h01, 30), 0, '0);
        add_row(mk(CMD_CPU_WRITE, 16'h8000, 8'h01, '1), 0, '0);
        add_row(mk(CMD_CPU_WRITE, 16'h8000, 8'h01, 40), 0, '0);
        add_row(mk(CMD_CPU_WRITE, 16'hFFFF, 8'h00, 50), 0, '0);
        add_row(mk(CMD_CPU_WRITE, 16'hA000, 8'hFE, 60), 0, '0);
        add_row(mk(CMD_CPU_WRITE, 16'hE000, 8'h80, '1), 0, '0);
        add_row(mk(CMD_PRG_READ, 16'hC000, 0, 0), 0, '0);
        add_row(mk(CMD_CHR_WRITE, 16'h1000, 0, 0), 0, '0);
        add_row(mk(CMD_PRG_RAM, 16'h5FFF, 0, 0), 0, '0);
        foreach (dir_rows[i]) send_access(dir_rows[i].it, dir_rows[i].fixed, dir_rows[i].res);
        drain(100);
        cyc_now = 64'd1000;

        for (phase = 0; phase < 12; phase++) begin
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 86; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 86; end
                default: begin send_idle_pct = 28; recv_stall_pct = 28; end
            endcase
            drain(100);
            write_reg(REG_VARIANT, 20'(phase % 4));
            write_reg(REG_PRG_ROM_SIZE, prg_sizes[phase % 6]);
            write_reg(REG_CHR_ROM_SIZE, chr_sizes[phase % 5]);
            write_reg(REG_CHR_RAM_SIZE, (phase % 3 == 2) ? 20'h0 :
                                        ((phase % 3 == 1) ? 20'h20000 : 20'h2000));
            write_reg(REG_PRG_RAM_SIZE, ram_sizes[phase % 5]);
            cfg_valid <= 1'b0;
            for (int n = 0; n < 76; n++) begin
                if ($urandom_range(3) == 0)
                    serial_load(16'h8000 | {1'b0, 2'($urandom_range(3)), 13'd0},
                                5'($urandom));
                else
                    send_access(rand_access(), 0, '0);
                if (n == 38 && phase == 5) drain(0);
            end
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;
        drain(100);

        $display("covered %0d results over 12 register settings, all variants and idle mixes",
                 out_count);
        if (err_count == 0 && expected_q.size() == 0) begin
            $display("serial_bank_switch_mapper_unit: match");
        end else begin
            $display("%0d mismatches", err_count);
            $display("serial_bank_switch_mapper_unit: mismatch");
        end
        $finish;
    end
endmodule
`default_nettype wire
